[hdl/ehash_pkg.sv]
package ehash_pkg;

  localparam int MAX_GLOBAL_DEPTH = 8;
  localparam int BUCKET_SLOTS = 4;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_DEPTH     = 2'd2;
  localparam logic [1:0] STAT_ZERO_VAL  = 2'd3;

  localparam logic CFG_INIT_DEPTH = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CLR_START, CMD_CLR_STEP, CMD_CLR_END,
    CMD_DIR_RD, CMD_META_RD, CMD_META_LATCH, CMD_SLOT_RD, CMD_SLOT_CMP,
    CMD_STORE, CMD_DBL_START, CMD_DBL_RD, CMD_DBL_WR, CMD_DBL_END,
    CMD_SPL_START, CMD_SPL_RD, CMD_SPL_WR, CMD_SPL_META0, CMD_SPL_META1,
    CMD_DIRU_RD, CMD_DIRU_WR, CMD_SPL_END
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t    code;
    logic       res_en;
    logic [1:0] res_status;
    logic       publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       val_zero;
    logic       fits;
    logic       ld_ge_gl;
    logic       gl_max;
    logic       nfb_full;
    logic       scan_done;
    logic       hit;
    logic       half_done;
    logic       clr_last;
    logic       iter_done;
  } dp_flags_t;

endpackage

[hdl/ehash_ram.sv]
module ehash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ehash_dp.sv]
module ehash_dp #(
  parameter int MAX_GLOBAL_DEPTH = ehash_pkg::MAX_GLOBAL_DEPTH,
  parameter int BUCKET_SLOTS = ehash_pkg::BUCKET_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_data,
  input  logic [71:0]          in_tdata,
  input  ehash_pkg::ctrl_cmd_t cmd,
  output ehash_pkg::dp_flags_t flags,
  output logic [39:0]          out_tdata
);

  localparam int MGD = MAX_GLOBAL_DEPTH;
  localparam int DIR_SIZE = 1 << MGD;
  localparam int LW = $clog2(MGD + 1);
  localparam int FW = $clog2(BUCKET_SLOTS + 1);
  localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int IW = (MGD + 1 > FW) ? MGD + 1 : FW;
  localparam int ITER_LIM = 2 * MGD + 4;
  localparam int ITW = $clog2(ITER_LIM + 1);
  localparam int SAW = MGD + SW;
  localparam int MW = LW + FW;

  logic [1:0]    op_r;
  logic [31:0]   key_r, val_r;
  logic [LW-1:0] gl, d_r, ld;
  logic [MGD:0]  nfb;
  logic [MGD-1:0] b_r;
  logic [FW-1:0] fc, lo, hi;
  logic [IW-1:0] idx;
  logic [ITW-1:0] iter;
  logic [1:0]    status_r;
  logic [31:0]   found_r;
  logic [3:0]    init_depth;
  logic [2:0]    bcap;
  logic [1:0]    out_status;
  logic [31:0]   out_found;
  logic [3:0]    out_depth;

  logic           dir_we, meta_we, slot_we;
  logic [MGD-1:0] dir_waddr, dir_wdata, dir_raddr, dir_rdata;
  logic [MGD-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  logic [63:0]    slot_wdata, slot_rdata;

  logic [IW-1:0]  half, gmask, dmask, dbl_addr, idx_shift;
  logic [MGD-1:0] key_idx;
  logic [7:0]     cap_eff;
  logic [FW-1:0]  n_eff;
  logic [LW-1:0]  d_clamp;
  logic [31:0]    key_shift;
  logic [LW-1:0]  ld_inc;

  ehash_ram #(.WIDTH(MGD), .DEPTH(DIR_SIZE)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  ehash_ram #(.WIDTH(MW), .DEPTH(DIR_SIZE)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  ehash_ram #(.WIDTH(64), .DEPTH(DIR_SIZE << SW)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  always_comb begin
    half      = IW'(1) << gl;
    gmask     = half - IW'(1);
    dmask     = (IW'(1) << d_r) - IW'(1);
    key_idx   = key_r[MGD-1:0] & gmask[MGD-1:0];
    dbl_addr  = idx + half;
    idx_shift = idx >> ld;
    key_shift = slot_rdata[31:0] >> ld;
    ld_inc    = ld + LW'(1);
    if (bcap == 3'd0) begin
      cap_eff = 8'd1;
    end else if (8'(bcap) > 8'(BUCKET_SLOTS)) begin
      cap_eff = 8'(BUCKET_SLOTS);
    end else begin
      cap_eff = 8'(bcap);
    end
    n_eff   = (8'(fc) > 8'(BUCKET_SLOTS)) ? FW'(BUCKET_SLOTS) : fc;
    d_clamp = (8'(init_depth) > 8'(MGD)) ? LW'(MGD) : LW'(init_depth);
  end

  always_comb begin
    flags.op        = op_r;
    flags.val_zero  = (val_r == 32'd0);
    flags.fits      = (8'(fc) < cap_eff);
    flags.ld_ge_gl  = (ld >= gl);
    flags.gl_max    = (gl >= LW'(MGD));
    flags.nfb_full  = nfb[MGD];
    flags.scan_done = (16'(idx) >= 16'(n_eff));
    flags.hit       = (slot_rdata[31:0] == key_r);
    flags.half_done = (idx == half);
    flags.clr_last  = (idx == IW'(DIR_SIZE - 1));
    flags.iter_done = (iter == ITW'(ITER_LIM));
  end

  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = idx[MGD-1:0];
    dir_wdata  = dir_rdata;
    dir_raddr  = idx[MGD-1:0];
    meta_we    = 1'b0;
    meta_waddr = b_r;
    meta_wdata = {ld_inc, lo};
    meta_raddr = dir_rdata;
    slot_we    = 1'b0;
    slot_waddr = {b_r, lo[SW-1:0]};
    slot_wdata = slot_rdata;
    slot_raddr = {b_r, idx[SW-1:0]};
    case (cmd.code)
      ehash_pkg::CMD_CLR_STEP: begin
        dir_we     = 1'b1;
        dir_wdata  = idx[MGD-1:0] & dmask[MGD-1:0];
        meta_we    = 1'b1;
        meta_waddr = idx[MGD-1:0];
        meta_wdata = {d_r, FW'(0)};
      end
      ehash_pkg::CMD_DIR_RD: dir_raddr = key_idx;
      ehash_pkg::CMD_STORE: begin
        slot_we    = 1'b1;
        slot_waddr = {b_r, fc[SW-1:0]};
        slot_wdata = {val_r, key_r};
        meta_we    = 1'b1;
        meta_wdata = {ld, fc + FW'(1)};
      end
      ehash_pkg::CMD_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = dbl_addr[MGD-1:0];
      end
      ehash_pkg::CMD_SPL_WR: begin
        slot_we = 1'b1;
        // one half moves to the fresh bucket, the zero half compacts in place
        if (key_shift[0]) begin
          slot_waddr = {nfb[MGD-1:0], hi[SW-1:0]};
        end
      end
      ehash_pkg::CMD_SPL_META0: meta_we = 1'b1;
      ehash_pkg::CMD_SPL_META1: begin
        meta_we    = 1'b1;
        meta_waddr = nfb[MGD-1:0];
        meta_wdata = {ld_inc, hi};
      end
      ehash_pkg::CMD_DIRU_WR: begin
        dir_we    = (dir_rdata == b_r) && idx_shift[0];
        dir_wdata = nfb[MGD-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_depth <= 4'd2;
      bcap       <= 3'd3;
      gl         <= LW'(0);
      nfb        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ehash_pkg::CFG_INIT_DEPTH) begin
          init_depth <= cfg_data;
        end else begin
          bcap <= cfg_data[2:0];
        end
      end
      case (cmd.code)
        ehash_pkg::CMD_CLR_END: begin
          gl  <= d_r;
          nfb <= (MGD + 1)'(1) << d_r;
        end
        ehash_pkg::CMD_DBL_END: gl <= gl + LW'(1);
        ehash_pkg::CMD_SPL_END: nfb <= nfb + (MGD + 1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      ehash_pkg::CMD_LOAD: begin
        op_r     <= in_tdata[1:0];
        key_r    <= in_tdata[33:2];
        val_r    <= in_tdata[65:34];
        status_r <= ehash_pkg::STAT_OK;
        found_r  <= 32'd0;
        iter     <= '0;
      end
      ehash_pkg::CMD_CLR_START: begin
        idx <= '0;
        d_r <= d_clamp;
      end
      ehash_pkg::CMD_CLR_STEP, ehash_pkg::CMD_DBL_WR, ehash_pkg::CMD_DIRU_WR:
        idx <= idx + IW'(1);
      ehash_pkg::CMD_META_RD: b_r <= dir_rdata;
      ehash_pkg::CMD_META_LATCH: begin
        {ld, fc} <= meta_rdata;
        idx      <= '0;
      end
      ehash_pkg::CMD_SLOT_CMP: begin
        if (flags.hit) begin
          found_r <= slot_rdata[63:32];
        end
        idx <= idx + IW'(1);
      end
      ehash_pkg::CMD_DBL_START, ehash_pkg::CMD_SPL_META1: idx <= '0;
      ehash_pkg::CMD_SPL_START: begin
        idx <= '0;
        lo  <= '0;
        hi  <= '0;
      end
      ehash_pkg::CMD_SPL_WR: begin
        idx <= idx + IW'(1);
        if (key_shift[0]) begin
          hi <= hi + FW'(1);
        end else begin
          lo <= lo + FW'(1);
        end
      end
      ehash_pkg::CMD_SPL_END: iter <= iter + ITW'(1);
      default: ;
    endcase
    if (cmd.res_en) begin
      status_r <= cmd.res_status;
    end
    if (cmd.publish) begin
      out_status <= status_r;
      out_found  <= found_r;
      out_depth  <= 4'(gl);
    end
  end

  assign out_tdata = {2'b00, out_depth, out_found, out_status};

endmodule

[hdl/ehash_ctrl.sv]
module ehash_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ehash_pkg::dp_flags_t flags,
  output ehash_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_CLR_LOOP, S_CLR_END, S_IDLE, S_DISPATCH, S_DIR_RD, S_META_RD,
    S_LATCH, S_SRCH_CHK, S_SRCH_CMP, S_INS_CHK, S_DBL_RD, S_DBL_WR,
    S_SPL_CHK, S_SPL_RD, S_SPL_WR, S_SPL_M1, S_DIRU_RD, S_DIRU_WR,
    S_NEXT, S_DONE
  } state_t;

  state_t state, state_next;
  logic   init_pass;

  always_comb begin
    state_next     = state;
    cmd.code       = ehash_pkg::CMD_NONE;
    cmd.res_en     = 1'b0;
    cmd.res_status = ehash_pkg::STAT_OK;
    cmd.publish    = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.code   = ehash_pkg::CMD_CLR_START;
        state_next = S_CLR_LOOP;
      end
      S_CLR_LOOP: begin
        cmd.code = ehash_pkg::CMD_CLR_STEP;
        if (flags.clr_last) begin
          state_next = S_CLR_END;
        end
      end
      S_CLR_END: begin
        cmd.code = ehash_pkg::CMD_CLR_END;
        // the pass after reset delivers no item
        state_next = init_pass ? S_IDLE : S_DONE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.code   = ehash_pkg::CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (flags.op)
          ehash_pkg::OP_SEARCH: state_next = S_DIR_RD;
          ehash_pkg::OP_INSERT: begin
            if (flags.val_zero) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ehash_pkg::STAT_ZERO_VAL;
              state_next     = S_DONE;
            end else begin
              state_next = S_DIR_RD;
            end
          end
          ehash_pkg::OP_CLEAR: begin
            cmd.code   = ehash_pkg::CMD_CLR_START;
            state_next = S_CLR_LOOP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIR_RD: begin
        cmd.code   = ehash_pkg::CMD_DIR_RD;
        state_next = S_META_RD;
      end
      S_META_RD: begin
        cmd.code   = ehash_pkg::CMD_META_RD;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.code   = ehash_pkg::CMD_META_LATCH;
        state_next = (flags.op == ehash_pkg::OP_SEARCH) ? S_SRCH_CHK : S_INS_CHK;
      end
      S_SRCH_CHK: begin
        if (flags.scan_done) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ehash_pkg::STAT_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.code   = ehash_pkg::CMD_SLOT_RD;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.code = ehash_pkg::CMD_SLOT_CMP;
        if (flags.hit) begin
          cmd.res_en = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SRCH_CHK;
        end
      end
      S_INS_CHK: begin
        if (flags.fits) begin
          cmd.code   = ehash_pkg::CMD_STORE;
          cmd.res_en = 1'b1;
          state_next = S_DONE;
        end else if (flags.ld_ge_gl) begin
          if (flags.gl_max) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ehash_pkg::STAT_DEPTH;
            state_next     = S_DONE;
          end else begin
            cmd.code   = ehash_pkg::CMD_DBL_START;
            state_next = S_DBL_RD;
          end
        end else begin
          state_next = S_SPL_CHK;
        end
      end
      S_DBL_RD: begin
        if (flags.half_done) begin
          cmd.code   = ehash_pkg::CMD_DBL_END;
          state_next = S_SPL_CHK;
        end else begin
          cmd.code   = ehash_pkg::CMD_DBL_RD;
          state_next = S_DBL_WR;
        end
      end
      S_DBL_WR: begin
        cmd.code   = ehash_pkg::CMD_DBL_WR;
        state_next = S_DBL_RD;
      end
      S_SPL_CHK: begin
        if (flags.nfb_full) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ehash_pkg::STAT_DEPTH;
          state_next     = S_DONE;
        end else begin
          cmd.code   = ehash_pkg::CMD_SPL_START;
          state_next = S_SPL_RD;
        end
      end
      S_SPL_RD: begin
        if (flags.scan_done) begin
          cmd.code   = ehash_pkg::CMD_SPL_META0;
          state_next = S_SPL_M1;
        end else begin
          cmd.code   = ehash_pkg::CMD_SPL_RD;
          state_next = S_SPL_WR;
        end
      end
      S_SPL_WR: begin
        cmd.code   = ehash_pkg::CMD_SPL_WR;
        state_next = S_SPL_RD;
      end
      S_SPL_M1: begin
        cmd.code   = ehash_pkg::CMD_SPL_META1;
        state_next = S_DIRU_RD;
      end
      S_DIRU_RD: begin
        if (flags.half_done) begin
          cmd.code   = ehash_pkg::CMD_SPL_END;
          state_next = S_NEXT;
        end else begin
          cmd.code   = ehash_pkg::CMD_DIRU_RD;
          state_next = S_DIRU_WR;
        end
      end
      S_DIRU_WR: begin
        cmd.code   = ehash_pkg::CMD_DIRU_WR;
        state_next = S_DIRU_RD;
      end
      S_NEXT: begin
        if (flags.iter_done) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ehash_pkg::STAT_DEPTH;
          state_next     = S_DONE;
        end else begin
          state_next = S_DIR_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_pass <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR_END) begin
        init_pass <= 1'b0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

[hdl/extendible_hash_table.sv]
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: operation, key, value
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: status, found_value, depth_now
// cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One item at a time. A search scans the filled slots of its bucket until a hit; an insert
// that fits is stored in its bucket, else it may first double the directory and split the
// bucket. Reset and clear both run a pass over the directory and bucket RAMs; no item is
// taken during the pass after reset.
// The next item is taken while a result waits in the output register.
module extendible_hash_table #(
  parameter int MAX_GLOBAL_DEPTH = ehash_pkg::MAX_GLOBAL_DEPTH,
  parameter int BUCKET_SLOTS = ehash_pkg::BUCKET_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // operation[1:0], key[33:2], value[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[1:0], found_value[33:2], depth_now[37:34]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  ehash_pkg::ctrl_cmd_t cmd;
  ehash_pkg::dp_flags_t flags;

  assign cfg_ready = 1'b1;

  ehash_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .flags(flags), .cmd(cmd)
  );

  ehash_dp #(
    .MAX_GLOBAL_DEPTH(MAX_GLOBAL_DEPTH),
    .BUCKET_SLOTS(BUCKET_SLOTS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tdata(s_axis_tdata), .cmd(cmd), .flags(flags), .out_tdata(m_axis_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while busy");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("item taken during reset clearing pass");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[37:34]) <= 32'(MAX_GLOBAL_DEPTH)))
    else $error("global depth beyond limit");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten");

endmodule
